>>> design/citb_pkg.sv
// Shared types, register map and step functions for the CIA timer interrupt block.
`default_nettype none

package citb_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   localparam logic [3:0] REG_PRA      = 4'd0;
   localparam logic [3:0] REG_PRB      = 4'd1;
   localparam logic [3:0] REG_DDRA     = 4'd2;
   localparam logic [3:0] REG_DDRB     = 4'd3;
   localparam logic [3:0] REG_TA_LO    = 4'd4;
   localparam logic [3:0] REG_TA_HI    = 4'd5;
   localparam logic [3:0] REG_TB_LO    = 4'd6;
   localparam logic [3:0] REG_TB_HI    = 4'd7;
   localparam logic [3:0] REG_TOD_10TH = 4'd8;
   localparam logic [3:0] REG_TOD_SEC  = 4'd9;
   localparam logic [3:0] REG_TOD_MIN  = 4'd10;
   localparam logic [3:0] REG_TOD_HR   = 4'd11;
   localparam logic [3:0] REG_SDR      = 4'd12;
   localparam logic [3:0] REG_ICR      = 4'd13;
   localparam logic [3:0] REG_CRA      = 4'd14;
   localparam logic [3:0] REG_CRB      = 4'd15;

   localparam logic [7:0] CR_START     = 8'h01;
   localparam logic [7:0] CR_ONESHOT   = 8'h08;
   localparam logic [7:0] CR_LOAD      = 8'h10;
   localparam logic [7:0] CRA_INMODE   = 8'h20;
   localparam logic [7:0] CRB_INMODE   = 8'h40;
   localparam logic [7:0] CR_READ_MASK = 8'hEF;

   localparam logic [7:0] PA_DDR_MASK  = 8'h3F;
   localparam logic [7:0] PORT_RESET   = 8'hFF;

   localparam int         IMR_WIDTH    = 5;
   localparam int         ICR_IR_BIT   = 7;
   localparam int         ICR_TA_BIT   = 0;
   localparam int         ICR_TB_BIT   = 1;

   localparam logic [15:0] TOD_PERIOD_RESET = 16'd4410;
   localparam logic [7:0]  TENTHS_LAST      = 8'd9;
   localparam logic [7:0]  MINSEC_LAST      = 8'd59;
   localparam logic [7:0]  HOUR_LAST        = 8'd11;
   localparam logic [7:0]  HOUR_MASK        = 8'h1F;
   localparam logic [7:0]  HOUR_PM          = 8'h80;

   typedef logic [3:0][7:0] tod_type;

   typedef struct packed {
      logic [7:0]  ctrl;
      logic [15:0] count;
      logic        underflow;
   } timer_next_type;

   function automatic timer_next_type timer_step(input logic [7:0]  ctrl,
                                                 input logic [15:0] count,
                                                 input logic [15:0] latch,
                                                 input logic [7:0]  src_bit,
                                                 input logic [15:0] elapsed);
      timer_next_type r;
      r.ctrl      = ctrl;
      r.count     = count;
      r.underflow = 1'b0;
      if ((ctrl & CR_LOAD) != 8'h00) begin
         r.count = latch;
      end else if ((ctrl & (src_bit | CR_START)) == CR_START) begin
         if (count <= elapsed) begin
            r.count     = latch;
            r.underflow = 1'b1;
            if ((ctrl & CR_ONESHOT) != 8'h00) begin
               r.ctrl = ctrl & ~CR_START;
            end
         end else begin
            r.count = count - elapsed;
         end
      end
      r.ctrl = r.ctrl & ~CR_LOAD;
      return r;
   endfunction

   function automatic tod_type tod_advance(input tod_type t);
      tod_type r;
      r = t;
      if (t[0] < TENTHS_LAST) begin
         r[0] = t[0] + 8'd1;
      end else begin
         r[0] = 8'd0;
         if (t[1] < MINSEC_LAST) begin
            r[1] = t[1] + 8'd1;
         end else begin
            r[1] = 8'd0;
            if (t[2] < MINSEC_LAST) begin
               r[2] = t[2] + 8'd1;
            end else begin
               r[2] = 8'd0;
               if ((t[3] & HOUR_MASK) < HOUR_LAST) begin
                  r[3] = t[3] + 8'd1;
               end else begin
                  r[3] = (t[3] & HOUR_PM) ^ HOUR_PM;
               end
            end
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> design/cia_timer_interrupt_block_unit.sv
// Top level of the CIA timer interrupt block: ports, timers, time of day, interrupts.
//
// Usage: each req beat is a register write, a register read or a time tick
// (req_tuser selects which). Every req beat yields exactly one rsp beat with
// the read data, an irq flag and the video bank base selected by port A.
// The csr channel writes the tenth-second tick period; csr_ready is always
// high and writes are expected only while no beat is in flight.
// A req beat passes through two registers, the input register and then the
// result register, which holds the rsp beat until rsp_tready takes it.
// Throughput: one beat per cycle while rsp_tready keeps up; all register, timer
// and clock updates for a beat are done combinationally between those two registers.
// When rsp_tready is low the result register holds its beat; the input
// register still takes one more beat, then req_tready drops until the
// result register drains.
// Reset (synchronous, active high) empties both registers, sets the port
// data registers to all ones, the tick period to 4410 and the other register,
// timer, clock and interrupt state to zero; the beat data in the two registers is not reset.
`default_nettype none

module cia_timer_interrupt_block_unit
   import citb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // reg_addr[3:0], wdata[11:4], elapsed_cycles[27:12], zero
   input  wire logic [1:0]  req_tuser,   // cmd[1:0]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata    // rdata[7:0], irq[8], vic_base[24:9], zero
);

   logic                 s1_valid_ff, s1_valid_in;
   cmd_type              cmd_ff;
   logic [3:0]           addr_ff;
   logic [7:0]           wdata_ff;
   logic [15:0]          elapsed_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rdata_ff, rdata_in;
   logic                 irq_ff, irq_in;
   logic [15:0]          vic_base_ff, vic_base_in;

   logic [15:0]          period_ff, period_in;
   logic [7:0]           pra_ff, pra_in, prb_ff, prb_in;
   logic [7:0]           ddra_ff, ddra_in, ddrb_ff, ddrb_in;
   logic [15:0]          ta_latch_ff, ta_latch_in, tb_latch_ff, tb_latch_in;
   logic [15:0]          ta_count_ff, ta_count_in, tb_count_ff, tb_count_in;
   tod_type              tod_ff, tod_in;
   logic [7:0]           sdr_ff, sdr_in;
   logic [IMR_WIDTH-1:0] imr_ff, imr_in;
   logic [7:0]           icr_ff, icr_in;
   logic [7:0]           cra_ff, cra_in, crb_ff, crb_in;
   logic [15:0]          divider_ff, divider_in;

   logic                 s1_fire;
   timer_next_type       ta_next, tb_next;

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, vic_base_ff, irq_ff, rdata_ff};

   assign s1_valid_in  = (req_tvalid && req_tready) || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_tready);
   assign period_in    = (csr_valid && csr_ready) ? csr_wdata : period_ff;

   assign ta_next = timer_step(cra_ff, ta_count_ff, ta_latch_ff, CRA_INMODE, elapsed_ff);
   assign tb_next = timer_step(crb_ff, tb_count_ff, tb_latch_ff, CRB_INMODE, elapsed_ff);

   always_comb begin
      logic [7:0] flags;
      logic       irq_a;
      logic       irq_b;
      pra_in      = pra_ff;
      prb_in      = prb_ff;
      ddra_in     = ddra_ff;
      ddrb_in     = ddrb_ff;
      ta_latch_in = ta_latch_ff;
      tb_latch_in = tb_latch_ff;
      ta_count_in = ta_count_ff;
      tb_count_in = tb_count_ff;
      tod_in      = tod_ff;
      sdr_in      = sdr_ff;
      imr_in      = imr_ff;
      icr_in      = icr_ff;
      cra_in      = cra_ff;
      crb_in      = crb_ff;
      divider_in  = divider_ff;
      rdata_in    = 8'd0;
      irq_in      = 1'b0;
      flags       = icr_ff;
      irq_a       = ta_next.underflow && imr_ff[ICR_TA_BIT];
      irq_b       = tb_next.underflow && imr_ff[ICR_TB_BIT];

      case (cmd_ff)
         CMD_WRITE: begin
            unique case (addr_ff) inside
               REG_PRA:   pra_in  = wdata_ff;
               REG_PRB:   prb_in  = wdata_ff;
               REG_DDRA:  ddra_in = wdata_ff;
               REG_DDRB:  ddrb_in = wdata_ff;
               REG_TA_LO: ta_latch_in = {ta_latch_ff[15:8], wdata_ff};
               REG_TA_HI: ta_latch_in = {wdata_ff, ta_latch_ff[7:0]};
               REG_TB_LO: tb_latch_in = {tb_latch_ff[15:8], wdata_ff};
               REG_TB_HI: tb_latch_in = {wdata_ff, tb_latch_ff[7:0]};
               REG_TOD_10TH, REG_TOD_SEC, REG_TOD_MIN, REG_TOD_HR:
                  tod_in[addr_ff[1:0]] = wdata_ff;
               REG_SDR:   sdr_in  = wdata_ff;
               REG_ICR: begin
                  if (wdata_ff[ICR_IR_BIT]) begin
                     imr_in = imr_ff | wdata_ff[IMR_WIDTH-1:0];
                  end else begin
                     imr_in = imr_ff & ~wdata_ff[IMR_WIDTH-1:0];
                  end
               end
               REG_CRA:   cra_in  = wdata_ff;
               default:   crb_in  = wdata_ff;
            endcase
         end
         CMD_READ: begin
            unique case (addr_ff) inside
               REG_PRA:   rdata_in = pra_ff | ~(ddra_ff & PA_DDR_MASK);
               REG_PRB:   rdata_in = prb_ff & ddrb_ff;
               REG_DDRA:  rdata_in = ddra_ff;
               REG_DDRB:  rdata_in = ddrb_ff;
               REG_TA_LO: rdata_in = ta_count_ff[7:0];
               REG_TA_HI: rdata_in = ta_count_ff[15:8];
               REG_TB_LO: rdata_in = tb_count_ff[7:0];
               REG_TB_HI: rdata_in = tb_count_ff[15:8];
               REG_TOD_10TH, REG_TOD_SEC, REG_TOD_MIN, REG_TOD_HR:
                  rdata_in = tod_ff[addr_ff[1:0]];
               REG_SDR:   rdata_in = sdr_ff;
               REG_ICR: begin
                  if (icr_ff[ICR_IR_BIT]) begin
                     rdata_in = {1'b1, 5'd0, icr_ff[ICR_TB_BIT], icr_ff[ICR_TA_BIT]};
                  end
                  icr_in = 8'd0;
               end
               REG_CRA:   rdata_in = cra_ff & CR_READ_MASK;
               default:   rdata_in = crb_ff & CR_READ_MASK;
            endcase
         end
         CMD_TICK: begin
            cra_in      = ta_next.ctrl;
            crb_in      = tb_next.ctrl;
            ta_count_in = ta_next.count;
            tb_count_in = tb_next.count;
            flags[ICR_TA_BIT] = icr_ff[ICR_TA_BIT] | ta_next.underflow;
            flags[ICR_TB_BIT] = icr_ff[ICR_TB_BIT] | tb_next.underflow;
            flags[ICR_IR_BIT] = icr_ff[ICR_IR_BIT] | irq_a | irq_b;
            icr_in      = flags;
            irq_in      = irq_a | irq_b;
            if (divider_ff <= 16'd1) begin
               divider_in = period_ff;
               tod_in     = tod_advance(tod_ff);
            end else begin
               divider_in = divider_ff - 16'd1;
            end
         end
         default: begin
         end
      endcase

      vic_base_in = {~pra_in[1:0], 14'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         period_ff    <= TOD_PERIOD_RESET;
         pra_ff       <= PORT_RESET;
         prb_ff       <= PORT_RESET;
         ddra_ff      <= 8'd0;
         ddrb_ff      <= 8'd0;
         ta_latch_ff  <= 16'd0;
         tb_latch_ff  <= 16'd0;
         ta_count_ff  <= 16'd0;
         tb_count_ff  <= 16'd0;
         tod_ff       <= '0;
         sdr_ff       <= 8'd0;
         imr_ff       <= '0;
         icr_ff       <= 8'd0;
         cra_ff       <= 8'd0;
         crb_ff       <= 8'd0;
         divider_ff   <= 16'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         period_ff    <= period_in;
         if (s1_fire) begin
            pra_ff      <= pra_in;
            prb_ff      <= prb_in;
            ddra_ff     <= ddra_in;
            ddrb_ff     <= ddrb_in;
            ta_latch_ff <= ta_latch_in;
            tb_latch_ff <= tb_latch_in;
            ta_count_ff <= ta_count_in;
            tb_count_ff <= tb_count_in;
            tod_ff      <= tod_in;
            sdr_ff      <= sdr_in;
            imr_ff      <= imr_in;
            icr_ff      <= icr_in;
            cra_ff      <= cra_in;
            crb_ff      <= crb_in;
            divider_ff  <= divider_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff     <= cmd_type'(req_tuser);
         addr_ff    <= req_tdata[3:0];
         wdata_ff   <= req_tdata[11:4];
         elapsed_ff <= req_tdata[27:12];
      end
      if (s1_fire) begin
         rdata_ff    <= rdata_in;
         irq_ff      <= irq_in;
         vic_base_ff <= vic_base_in;
      end
   end

endmodule

`default_nettype wire
